// ===== rtl/core/pwm_period_duty_capture_top_macros.svh =====
`ifndef PWM_PERIOD_DUTY_CAPTURE_TOP_MACROS_SVH
`define PWM_PERIOD_DUTY_CAPTURE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define PDC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define PDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pdc_pkg.sv =====
package pdc_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int DUTY_WIDTH      = 7;
   localparam int DUTY_SCALE      = 100;
   localparam int DUTY_MAX        = 100;
   localparam int STEP_WIDTH      = $clog2(DUTY_WIDTH);
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_PERIOD_ZERO = 2'd1,
      STATUS_HIGH_OVER   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PHASE_START = 2'd0,
      PHASE_FALL  = 2'd1,
      PHASE_END   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      BACK_IDLE   = 2'd0,
      BACK_LOAD   = 2'd1,
      BACK_DIVIDE = 2'd2,
      BACK_EMIT   = 2'd3
   } back_state_type;

   typedef struct packed {
      logic                  arm_falling;
      logic                  done_res;
      logic [DATA_WIDTH-1:0] period_ticks;
      logic [DATA_WIDTH-1:0] high_ticks;
   } job_type;

   typedef struct packed {
      logic                  arm_falling;
      logic                  done_res;
      logic [DATA_WIDTH-1:0] period_ticks;
      logic [DATA_WIDTH-1:0] high_ticks;
      logic [DUTY_WIDTH-1:0] duty_percent;
      status_type            status;
   } rsp_item_type;

endpackage

// ===== rtl/core/pdc_front.sv =====
module pdc_front #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [pdc_pkg::DATA_WIDTH-1:0]  capture_time,
   input  logic                            push_ready,
   output logic                            push_valid,
   output pdc_pkg::job_type                push_job
);

   pdc_pkg::phase_type     phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] start_ff, start_in;
   logic [COUNT_WIDTH-1:0] fall_ff, fall_in;
   logic [COUNT_WIDTH-1:0] time_cw;
   logic [COUNT_WIDTH-1:0] period_cw;
   logic [COUNT_WIDTH-1:0] high_cw;
   logic                   accept;

   assign time_cw    = capture_time[COUNT_WIDTH-1:0];
   assign period_cw  = time_cw - start_ff;
   assign high_cw    = fall_ff - start_ff;
   assign push_valid = req_valid;
   assign accept     = req_valid & push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pdc_pkg::PHASE_START;
         start_ff <= '0;
         fall_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         fall_ff  <= fall_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      fall_in  = fall_ff;
      push_job = '0;
      case (phase_ff)
         pdc_pkg::PHASE_FALL: begin
            push_job.arm_falling = 1'b0;
            if (accept) begin
               fall_in  = time_cw;
               phase_in = pdc_pkg::PHASE_END;
            end
         end
         pdc_pkg::PHASE_END: begin
            push_job.arm_falling  = 1'b0;
            push_job.done_res     = 1'b1;
            push_job.period_ticks = pdc_pkg::DATA_WIDTH'(period_cw);
            push_job.high_ticks   = pdc_pkg::DATA_WIDTH'(high_cw);
            if (accept) begin
               phase_in = pdc_pkg::PHASE_START;
            end
         end
         default: begin
            push_job.arm_falling = 1'b1;
            if (accept) begin
               start_in = time_cw;
               phase_in = pdc_pkg::PHASE_FALL;
            end
         end
      endcase
   end

endmodule

// ===== rtl/core/pdc_queue.sv =====
module pdc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  pdc_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output pdc_pkg::job_type pop_job
);

   pdc_pkg::job_type                       entries_ff [pdc_pkg::QUEUE_DEPTH];
   logic [pdc_pkg::QUEUE_PTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [pdc_pkg::QUEUE_PTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [pdc_pkg::QUEUE_CNT_WIDTH-1:0]    count_ff, count_in;
   logic                                   do_push;
   logic                                   do_pop;

   assign push_ready = count_ff != pdc_pkg::QUEUE_CNT_WIDTH'(pdc_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/pdc_back.sv =====
module pdc_back #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  pdc_pkg::job_type      job,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pdc_pkg::rsp_item_type rsp_item
);

   localparam int REM_WIDTH = COUNT_WIDTH + pdc_pkg::DUTY_WIDTH;

   pdc_pkg::back_state_type            state_ff, state_in;
   pdc_pkg::rsp_item_type              res_ff, res_in;
   pdc_pkg::rsp_item_type              out_ff, out_in;
   logic                               out_valid_ff, out_valid_in;
   logic [COUNT_WIDTH-1:0]             per_ff, per_in;
   logic [COUNT_WIDTH-1:0]             hi_ff, hi_in;
   logic [REM_WIDTH-1:0]               rem_ff, rem_in;
   logic [pdc_pkg::STEP_WIDTH-1:0]     step_ff, step_in;
   logic [REM_WIDTH-1:0]               divisor;
   logic [REM_WIDTH:0]                 diff;
   logic                               fits;

   assign divisor   = REM_WIDTH'(per_ff) << step_ff;
   assign diff      = {1'b0, rem_ff} - {1'b0, divisor};
   assign fits      = ~diff[REM_WIDTH];
   assign job_ready = state_ff == pdc_pkg::BACK_IDLE;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdc_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      out_ff  <= out_in;
      per_ff  <= per_in;
      hi_ff   <= hi_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      per_in       = per_ff;
      hi_in        = hi_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      case (state_ff)
         pdc_pkg::BACK_IDLE: begin
            if (job_valid) begin
               res_in.arm_falling  = job.arm_falling;
               res_in.done_res     = job.done_res;
               res_in.period_ticks = job.period_ticks;
               res_in.high_ticks   = job.high_ticks;
               res_in.duty_percent = '0;
               res_in.status       = pdc_pkg::STATUS_OK;
               per_in              = job.period_ticks[COUNT_WIDTH-1:0];
               hi_in               = job.high_ticks[COUNT_WIDTH-1:0];
               state_in            = pdc_pkg::BACK_LOAD;
            end
         end
         pdc_pkg::BACK_LOAD: begin
            rem_in   = REM_WIDTH'(hi_ff) * REM_WIDTH'(pdc_pkg::DUTY_SCALE);
            step_in  = pdc_pkg::STEP_WIDTH'(pdc_pkg::DUTY_WIDTH - 1);
            state_in = pdc_pkg::BACK_EMIT;
            if (res_ff.done_res) begin
               if (per_ff == '0) begin
                  res_in.status = pdc_pkg::STATUS_PERIOD_ZERO;
               end else if (hi_ff > per_ff) begin
                  res_in.duty_percent = pdc_pkg::DUTY_WIDTH'(pdc_pkg::DUTY_MAX);
                  res_in.status       = pdc_pkg::STATUS_HIGH_OVER;
               end else begin
                  state_in = pdc_pkg::BACK_DIVIDE;
               end
            end
         end
         pdc_pkg::BACK_DIVIDE: begin
            res_in.duty_percent = {res_ff.duty_percent[pdc_pkg::DUTY_WIDTH-2:0], fits};
            if (fits) begin
               rem_in = diff[REM_WIDTH-1:0];
            end
            if (step_ff == '0) begin
               state_in = pdc_pkg::BACK_EMIT;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         pdc_pkg::BACK_EMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = pdc_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = pdc_pkg::BACK_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/pwm_period_duty_capture_top.sv =====
// channel  direction  tdata fields (low bit up)                          tuser
// req      in         capture_time[31:0]                                 -
// rsp      out        arm_falling, period_ticks, high_ticks, duty, status done_res
//
// Edge transfers enter a two-entry queue at one per cycle while it has room.
// Every job passes the back end's load and emit states; a closing edge with a
// nonzero period, high not above it, also runs the seven-step restoring divider.
// The result register lets the next job finish while rsp is stalled.
// Reset clears phase, both edge times, the queue, back-end state and rsp valid.
`include "pwm_period_duty_capture_top_macros.svh"

module pwm_period_duty_capture_top #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // capture_time[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // arm_falling[0], period_ticks[32:1], high_ticks[64:33], duty_percent[71:65],
   // status[73:72], zero[79:74]
   output logic [79:0] rsp_tdata,
   output logic        rsp_tuser    // done_res
);

   logic                  push_valid;
   logic                  push_ready;
   pdc_pkg::job_type      push_job;
   logic                  pop_valid;
   logic                  pop_ready;
   pdc_pkg::job_type      pop_job;
   pdc_pkg::rsp_item_type rsp_item;

   pdc_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .capture_time (req_tdata),
      .push_ready   (push_ready),
      .push_valid   (push_valid),
      .push_job     (push_job)
   );

   pdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   pdc_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job       (pop_job),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign req_tready = push_ready;
   assign rsp_tuser  = rsp_item.done_res;
   assign rsp_tdata  = {6'b0, rsp_item.status, rsp_item.duty_percent,
                        rsp_item.high_ticks, rsp_item.period_ticks, rsp_item.arm_falling};

   `PDC_ASSERT_NOW(a_duty_range, clock, reset, rsp_tvalid,
      rsp_item.duty_percent <= 7'd100, "duty above 100 percent")
   `PDC_ASSERT_NOW(a_idle_zero, clock, reset, rsp_tvalid && !rsp_item.done_res,
      rsp_item.period_ticks == '0 && rsp_item.high_ticks == '0 &&
      rsp_item.duty_percent == '0 && rsp_item.status == pdc_pkg::STATUS_OK,
      "non-final edge carries measurement data")
   `PDC_ASSERT_NOW(a_zero_period, clock, reset,
      rsp_tvalid && rsp_item.status == pdc_pkg::STATUS_PERIOD_ZERO,
      rsp_item.period_ticks == '0 && rsp_item.duty_percent == '0,
      "zero period status with nonzero period or duty")
   `PDC_ASSERT_NEXT(a_pop_blocks, clock, reset, pop_valid && pop_ready,
      !pop_ready, "back end took a second job while busy")

endmodule

// ===== bench/pwm_period_duty_capture_top_test.sv =====
module pwm_period_duty_capture_top_test;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 10;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 30;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_PERCENT = 11;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;

   // predictor state
   pdc_pkg::phase_type             edge_phase = pdc_pkg::PHASE_START;
   logic [pdc_pkg::DATA_WIDTH-1:0] rise_time = '0;
   logic [pdc_pkg::DATA_WIDTH-1:0] fall_time = '0;

   pdc_pkg::rsp_item_type pending_results[$];

   bit steady = 1'b0;
   int hold_requests = 0;
   int hold_grants = 0;
   int hold_left = 0;

   int mismatch_count = 0;
   int edges_sent = 0;
   int results_seen = 0;
   int measurements_seen = 0;
   int zero_periods_seen = 0;
   int high_over_seen = 0;
   int cycle_count = 0;

   pwm_period_duty_capture_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at result %0d, %s: got %0h want %0h",
               results_seen, field, got, want);
      mismatch_count++;
   endtask

   function automatic void predict_edge(input logic [pdc_pkg::DATA_WIDTH-1:0] capture_time);
      pdc_pkg::rsp_item_type          result;
      logic [pdc_pkg::DATA_WIDTH-1:0] period;
      logic [pdc_pkg::DATA_WIDTH-1:0] high;
      logic [63:0]                    scaled;
      result = '0;
      case (edge_phase)
         pdc_pkg::PHASE_FALL: begin
            fall_time  = capture_time;
            edge_phase = pdc_pkg::PHASE_END;
         end
         pdc_pkg::PHASE_END: begin
            period = capture_time - rise_time;
            high   = fall_time - rise_time;
            result.done_res     = 1'b1;
            result.period_ticks = period;
            result.high_ticks   = high;
            if (period == '0) begin
               result.status = pdc_pkg::STATUS_PERIOD_ZERO;
            end else if (high > period) begin
               result.duty_percent = pdc_pkg::DUTY_WIDTH'(pdc_pkg::DUTY_MAX);
               result.status       = pdc_pkg::STATUS_HIGH_OVER;
            end else begin
               scaled = {32'b0, high} * 64'(pdc_pkg::DUTY_SCALE);
               result.duty_percent = pdc_pkg::DUTY_WIDTH'(scaled / {32'b0, period});
               result.status       = pdc_pkg::STATUS_OK;
            end
            edge_phase = pdc_pkg::PHASE_START;
         end
         default: begin
            rise_time          = capture_time;
            result.arm_falling = 1'b1;
            edge_phase         = pdc_pkg::PHASE_FALL;
         end
      endcase
      pending_results.push_back(result);
   endfunction

   // entered and left at a falling edge; valid stays high between back-to-back transfers
   task automatic send_edge(input logic [31:0] capture_time);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= capture_time;
      do @(posedge clock); while (!req_tready);
      predict_edge(capture_time);
      edges_sent++;
      @(negedge clock);
   endtask

   task automatic send_measurement(input logic [31:0] start, input logic [31:0] high,
                                   input logic [31:0] period);
      send_edge(start);
      send_edge(start + high);
      send_edge(start + period);
   endtask

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_requests != hold_grants) begin
         rsp_tready  <= 1'b0;
         hold_left   <= HOLD_CYCLES;
         hold_grants <= hold_requests;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      pdc_pkg::rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[63:0], '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[0] !== want.arm_falling)
               report_mismatch("arm_falling", 64'(rsp_tdata[0]), 64'(want.arm_falling));
            if (rsp_tuser !== want.done_res)
               report_mismatch("done_res", 64'(rsp_tuser), 64'(want.done_res));
            if (rsp_tdata[32:1] !== want.period_ticks)
               report_mismatch("period_ticks", 64'(rsp_tdata[32:1]),
                               64'(want.period_ticks));
            if (rsp_tdata[64:33] !== want.high_ticks)
               report_mismatch("high_ticks", 64'(rsp_tdata[64:33]), 64'(want.high_ticks));
            if (rsp_tdata[71:65] !== want.duty_percent)
               report_mismatch("duty_percent", 64'(rsp_tdata[71:65]),
                               64'(want.duty_percent));
            if (rsp_tdata[73:72] !== want.status)
               report_mismatch("status", 64'(rsp_tdata[73:72]), 64'(want.status));
            if (rsp_tdata[79:74] !== '0)
               report_mismatch("padding", 64'(rsp_tdata[79:74]), '0);
            if (want.done_res) measurements_seen++;
            if (want.status == pdc_pkg::STATUS_PERIOD_ZERO) zero_periods_seen++;
            if (want.status == pdc_pkg::STATUS_HIGH_OVER) high_over_seen++;
         end
      end
   end

   task automatic test_directed_cases();
      send_measurement(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_measurement(32'hffff_ffff, 32'h0000_0001, 32'h0000_0002);
      send_measurement(32'h0000_0064, 32'h0000_03e8, 32'h0000_03e8);
      send_measurement(32'h0000_0005, 32'h0000_000a, 32'h0000_0009);
      send_measurement(32'h8000_0000, 32'h0000_0000, 32'h0000_0007);
      send_measurement(32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff);
      send_measurement(32'haaaa_5555, 32'hffff_fffe, 32'hffff_ffff);
      send_measurement(32'h5555_aaaa, 32'h0000_0003, 32'h0000_00c8);
   endtask

   task automatic test_output_backpressure();
      steady = 1'b1;
      hold_requests++;
      repeat (10) send_measurement($urandom, $urandom_range(500), $urandom_range(1, 1000));
      steady = 1'b0;
   endtask

   task automatic test_random_measurements(input int count);
      logic [31:0] high;
      logic [31:0] period;
      for (int i = 0; i < count; i++) begin
         steady = (i >= 200 && i < 300);
         case ($urandom_range(9))
            0: begin
               period = '0;
               high   = $urandom;
            end
            1: begin
               period = $urandom_range(32'hffff_fffe);
               high   = period + 1 + $urandom_range(32'hffff_fffe - period);
            end
            2: begin
               period = $urandom;
               high   = period;
            end
            3: begin
               period = $urandom;
               high   = '0;
            end
            4, 5: begin
               period = $urandom_range(1, 1000);
               high   = $urandom_range(period);
            end
            6, 7: begin
               period = $urandom;
               high   = $urandom;
            end
            8: begin
               period = 32'hffff_ffff - $urandom_range(1000);
               high   = period - $urandom_range(1000);
            end
            default: begin
               period = $urandom_range(1, 32'hffff_ffff);
               high   = $urandom_range(period);
            end
         endcase
         send_measurement($urandom, high, period);
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_output_backpressure();
      test_random_measurements(500);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d edges and %0d measurements, %0d with zero period, %0d %s",
               edges_sent, measurements_seen, zero_periods_seen, high_over_seen,
               "with high over period");
      $display("with random stalls on both channels and one long output hold-off");
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
